>>> hdl/module_frame_encoder_top_defines.svh
// Assertion macros shared by the frame encoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MODULE_FRAME_ENCODER_TOP_DEFINES_SVH
`define MODULE_FRAME_ENCODER_TOP_DEFINES_SVH

// Checked while out of reset.
`define MFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mfe_pkg.sv
// Types and byte codes for the frame encoder.
// No dependencies; imported by mfe_expand, module_frame_encoder_top and tb_top.
package mfe_pkg;

  localparam logic [7:0] STX     = 8'h02;
  localparam logic [7:0] ETX     = 8'h03;
  localparam logic [7:0] DLE     = 8'h10;
  localparam logic [7:0] ESC_BIT = 8'h80;
  localparam logic [7:0] HDR_TAG = 8'h04;

  localparam int unsigned RUN_MAX = 8;

  typedef struct packed {
    logic [4:0] module_id;
    logic [4:0] payload_len;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } frm_word_t;

  // Expanded bytes caused by one command word.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [3:0]              cnt;
    logic                    ends_frame;
  } run_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == STX) || (b == ETX) || (b == DLE);
  endfunction

endpackage

>>> hdl/mfe_expand.sv
// Expands one command word into its run of framed, stuffed bytes.
// Depends on mfe_pkg. Purely combinational; used by module_frame_encoder_top.
module mfe_expand (
  input  mfe_pkg::cmd_word_t word,
  input  logic               in_frame,
  input  logic [15:0]        check_sum,
  output mfe_pkg::run_t      run,
  output logic [15:0]        sum_next
);
  import mfe_pkg::*;

  logic [15:0] seed;
  logic [15:0] folded;
  logic [7:0]  cks;
  logic [3:0]  pos;
  logic [3:0]  pos1;

  always_comb begin
    run    = '0;
    pos    = 4'd0;
    pos1   = 4'd0;
    seed   = in_frame ? check_sum : {11'd0, word.module_id};
    sum_next = seed + {8'd0, word.data_byte};
    folded = sum_next + {8'd0, sum_next[15:8]};
    cks    = folded[7:0];

    if (!in_frame) begin
      run.bytes[0] = STX;
      run.bytes[1] = HDR_TAG | {6'd0, word.module_id[4:3]};
      run.bytes[2] = {word.module_id[2:0], 5'd0} + {3'd0, word.payload_len};
      pos = 4'd3;
    end

    pos1 = pos + 4'd1;
    if (needs_esc(word.data_byte)) begin
      run.bytes[pos[2:0]]  = DLE;
      run.bytes[pos1[2:0]] = word.data_byte | ESC_BIT;
      pos = pos + 4'd2;
    end else begin
      run.bytes[pos[2:0]] = word.data_byte;
      pos = pos1;
    end

    if (word.last_byte) begin
      pos1 = pos + 4'd1;
      if (needs_esc(cks)) begin
        run.bytes[pos[2:0]]  = DLE;
        run.bytes[pos1[2:0]] = cks | ESC_BIT;
        pos = pos + 4'd2;
      end else begin
        run.bytes[pos[2:0]] = cks;
        pos = pos1;
      end
      run.bytes[pos[2:0]] = ETX;
      pos = pos + 4'd1;
      run.ends_frame = 1'b1;
    end

    run.cnt = pos;
  end

endmodule

>>> hdl/module_frame_encoder_top.sv
// Top level of the DLE byte-stuffing frame encoder with additive checksum.
// Depends on mfe_pkg, mfe_expand and module_frame_encoder_top_defines.svh.
//
//  channel  dir  payload     word
//  cmd      in   cmd_word_t  one raw payload byte with id, length, last flag
//  frm      out  frm_word_t  one byte of the framed serial stream
//
// A command word is expanded into a run buffer of 1 to 8 bytes,
// which drains at one frm word per cycle while frm_ready is high, set by the
// run buffer's single output port.
// A new cmd word is taken in the cycle the last byte of the run leaves.
// Synchronous active-high reset empties the buffer and clears frame state.
// frm stalls hold the run; cmd waits until the buffer frees.
`include "module_frame_encoder_top_defines.svh"

module module_frame_encoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mfe_pkg::cmd_word_t cmd,
  output logic               frm_valid,
  input  logic               frm_ready,
  output mfe_pkg::frm_word_t frm
);
  import mfe_pkg::*;

  logic        in_frame;
  logic [15:0] check_sum;
  logic [15:0] sum_next;
  run_t        run_next;
  run_t        run;
  logic        run_valid;
  logic [2:0]  idx;
  logic        final_byte;
  logic        cmd_take;
  logic        frm_take;

  mfe_expand u_expand (
    .word      (cmd),
    .in_frame  (in_frame),
    .check_sum (check_sum),
    .run       (run_next),
    .sum_next  (sum_next)
  );

  assign final_byte = ({1'b0, idx} == (run.cnt - 4'd1));
  assign frm_take   = frm_valid && frm_ready;
  assign cmd_ready  = !run_valid || (frm_ready && final_byte);
  assign cmd_take   = cmd_valid && cmd_ready;

  assign frm_valid     = run_valid;
  assign frm.out_byte  = run.bytes[idx];
  assign frm.run_last  = final_byte;
  assign frm.frame_end = run.ends_frame && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 3'd0;
      in_frame  <= 1'b0;
      check_sum <= 16'd0;
    end else begin
      if (cmd_take) begin
        run_valid <= 1'b1;
        idx       <= 3'd0;
        if (cmd.last_byte) begin
          in_frame  <= 1'b0;
          check_sum <= 16'd0;
        end else begin
          in_frame  <= 1'b1;
          check_sum <= sum_next;
        end
      end else if (frm_take) begin
        if (final_byte) begin
          run_valid <= 1'b0;
          idx       <= 3'd0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      run <= run_next;
    end
  end

  `MFE_ASSERT(a_run_holds, run_valid && !final_byte |=> run_valid, "run lost before its last byte")
  `MFE_ASSERT(a_etx_ends_run, frm_valid && frm.frame_end |-> frm.run_last && frm.out_byte == ETX, "frame end not on closing ETX")
  `MFE_ASSERT(a_last_closes, cmd_take && cmd.last_byte |=> !in_frame && check_sum == 16'd0, "frame state not cleared after last byte")
  `MFE_ASSERT(a_cnt_range, run_valid |-> run.cnt != 4'd0 && run.cnt <= 4'd8, "run length out of range")
  `MFE_ASSERT_ALWAYS(a_reset_empty, rst |=> !run_valid && !in_frame, "reset left state behind")

endmodule

>>> verif/tb_top.sv
// Self-checking bench for the DLE byte-stuffing frame encoder.
// Depends on mfe_pkg and module_frame_encoder_top; drives cmd words, checks frm words.
// Directed table first, then one long frame, then random frames with random stalls on both sides.
module tb_top;
  import mfe_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RAND_ITEMS      = 40;
  localparam int LONG_FRAME      = 270;
  localparam int DIR_ROWS        = 20;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_word_t cmd;
  logic      frm_valid;
  logic      frm_ready;
  frm_word_t frm;

  // n == 0: bytes come from the encoder model, else the row's own bytes
  typedef struct packed {
    cmd_word_t   w;
    logic [3:0]  n;
    logic [63:0] b;
  } dir_row_t;

  dir_row_t    dir_tab [DIR_ROWS];
  frm_word_t   serial_q [$];
  frm_word_t   run_buf [RUN_MAX];
  int          run_n;
  logic        open_frame;
  logic [15:0] run_sum;
  int          bad_words;
  bit          tx_calm;
  bit          rx_calm;

  module_frame_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cmd_word_t mk(input int id, input int len, input int data, input bit last);
    cmd_word_t w;
    w.module_id   = id[4:0];
    w.payload_len = len[4:0];
    w.data_byte   = data[7:0];
    w.last_byte   = last;
    return w;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic ends);
    run_buf[run_n] = '{b, 1'b0, ends};
    run_n++;
  endtask

  task automatic put_stuffed(input logic [7:0] b);
    if (b == STX || b == ETX || b == DLE) begin
      put_byte(DLE, 1'b0);
      put_byte(b | ESC_BIT, 1'b0);
    end else begin
      put_byte(b, 1'b0);
    end
  endtask

  task automatic encode_word(input cmd_word_t w);
    logic [15:0] folded;
    run_n = 0;
    if (!open_frame) begin
      put_byte(STX, 1'b0);
      put_byte({6'b0, w.module_id[4:3]} | HDR_TAG, 1'b0);
      put_byte({w.module_id[2:0], 5'b0} + {3'b0, w.payload_len}, 1'b0);
      run_sum    = {11'b0, w.module_id};
      open_frame = 1'b1;
    end
    put_stuffed(w.data_byte);
    run_sum = run_sum + {8'b0, w.data_byte};
    if (w.last_byte) begin
      // carry folded back into the low byte
      folded = run_sum + {8'b0, run_sum[15:8]};
      put_stuffed(folded[7:0]);
      put_byte(ETX, 1'b1);
      open_frame = 1'b0;
      run_sum    = '0;
    end
    run_buf[run_n-1].run_last = 1'b1;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input cmd_word_t w, input int gap, input logic [3:0] n_typed,
                           input logic [63:0] typed);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       = w;
    cmd_valid = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    encode_word(w);
    if (n_typed == 0) begin
      for (int i = 0; i < run_n; i++)
        serial_q.push_back(run_buf[i]);
    end else begin
      for (int i = 0; i < n_typed; i++)
        serial_q.push_back('{typed[63-8*i -: 8], i == n_typed - 1,
                             w.last_byte && (i == n_typed - 1)});
    end
    @(negedge clk);
  endtask

  task automatic drain_stream();
    cmd_valid = 1'b0;
    while (serial_q.size() != 0) @(negedge clk);
  endtask

  // frm side: random back-pressure with calm stretches
  initial begin
    int hold;
    hold      = 0;
    frm_ready = 1'b0;
    rx_calm   = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0)
        rx_calm = !rx_calm;
      if (hold > 0) begin
        hold--;
        frm_ready = 1'b0;
      end else begin
        hold      = pick_gap(rx_calm);
        frm_ready = (hold == 0);
        if (hold > 0)
          hold--;
      end
    end
  end

  always @(posedge clk) begin
    frm_word_t want;
    if (!rst && frm_valid && frm_ready) begin
      if (serial_q.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: byte %02h last %0d end %0d",
                   frm.out_byte, frm.run_last, frm.frame_end);
      end else begin
        want = serial_q.pop_front();
        if (frm.out_byte !== want.out_byte || frm.run_last !== want.run_last ||
            frm.frame_end !== want.frame_end) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: exp byte %02h last %0d end %0d, got byte %02h last %0d end %0d",
                     want.out_byte, want.run_last, want.frame_end,
                     frm.out_byte, frm.run_last, frm.frame_end);
        end
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (cmd_valid && cmd_ready) || (frm_valid && frm_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int        items;
    int        nb;
    int        id;
    int        len;
    int        data;
    bit        mid_drained;
    cmd_word_t w;

    rst         = 1'b1;
    cmd_valid   = 1'b0;
    cmd         = '0;
    open_frame  = 1'b0;
    run_sum     = '0;
    run_n       = 0;
    bad_words   = 0;
    tx_calm     = 1'b0;
    mid_drained = 1'b0;
    items       = 0;

    dir_tab[0]  = '{mk(0, 1, 8'h41, 1), 4'd6, 64'h0204_0141_4103_0000};
    dir_tab[1]  = '{mk(31, 31, 8'hFF, 1), 4'd6, 64'h0207_FFFF_1F03_0000};
    dir_tab[2]  = '{mk(0, 1, 8'h02, 1), 4'd8, 64'h0204_0110_8210_8203};
    dir_tab[3]  = '{mk(0, 0, 8'h03, 1), 4'd8, 64'h0204_0010_8310_8303};
    dir_tab[4]  = '{mk(0, 2, 8'h10, 0), 4'd5, 64'h0204_0210_9000_0000};
    dir_tab[5]  = '{mk(31, 5, 8'h00, 1), 4'd4, 64'h0010_9003_0000_0000};
    dir_tab[6]  = '{mk(2, 1, 8'h00, 1), 4'd7, 64'h0204_4100_1082_0300};
    dir_tab[7]  = '{mk(3, 1, 8'h00, 1), 4'd7, 64'h0204_6100_1083_0300};
    dir_tab[8]  = '{mk(8, 3, 8'hA5, 0), 4'd0, 64'h0};
    dir_tab[9]  = '{mk(0, 0, 8'h00, 0), 4'd0, 64'h0};
    dir_tab[10] = '{mk(21, 9, 8'hFF, 0), 4'd0, 64'h0};
    dir_tab[11] = '{mk(10, 30, 8'h80, 1), 4'd0, 64'h0};
    dir_tab[12] = '{mk(16, 31, 8'h7F, 0), 4'd0, 64'h0};
    dir_tab[13] = '{mk(1, 1, 8'hFF, 0), 4'd0, 64'h0};
    dir_tab[14] = '{mk(30, 17, 8'hFF, 0), 4'd0, 64'h0};
    dir_tab[15] = '{mk(5, 12, 8'hFF, 1), 4'd0, 64'h0};
    dir_tab[16] = '{mk(21, 10, 8'h01, 0), 4'd0, 64'h0};
    dir_tab[17] = '{mk(11, 20, 8'h04, 1), 4'd0, 64'h0};
    dir_tab[18] = '{mk(7, 1, 8'hFE, 1), 4'd6, 64'h0204_E1FE_0603_0000};
    dir_tab[19] = '{mk(16, 2, 8'hFF, 1), 4'd7, 64'h0206_02FF_1090_0300};

    repeat (7) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      send_word(dir_tab[r].w, pick_gap(1'b0), dir_tab[r].n, dir_tab[r].b);
    drain_stream();

    // long frame: running sum wraps past 16 bits
    id  = $urandom_range(0, 31);
    len = $urandom_range(0, 31);
    for (int k = 0; k < LONG_FRAME; k++)
      send_word(mk(id, len, $urandom_range(8'hF8, 8'hFF), k == LONG_FRAME - 1),
                pick_gap(1'b1), 4'd0, 64'h0);

    while (items < RAND_ITEMS) begin
      nb      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      id      = $urandom_range(0, 31);
      len     = $urandom_range(0, 1) ? nb : $urandom_range(0, 31);
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < nb; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 2))
            0:       data = STX;
            1:       data = ETX;
            default: data = DLE;
          endcase
        end else begin
          data = $urandom_range(0, 255);
        end
        // header fields past the first word are junk
        w = (k == 0) ? mk(id, len, data, k == nb - 1)
                     : mk($urandom_range(0, 31), $urandom_range(0, 31), data, k == nb - 1);
        send_word(w, pick_gap(tx_calm), 4'd0, 64'h0);
        items++;
      end
      if (!mid_drained && items >= RAND_ITEMS / 2) begin
        mid_drained = 1'b1;
        drain_stream();
      end
    end

    cmd_valid = 1'b0;
    while (serial_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (bad_words == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
